// ===== hdl/bit_stuffing_frame_builder_defines.svh =====
// Assertion macros for the bit-stuffing frame builder.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BIT_STUFFING_FRAME_BUILDER_DEFINES_SVH
`define BIT_STUFFING_FRAME_BUILDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsfb assertion failed in current cycle");

// Consequent must hold in the cycle after the antecedent.
`define BSFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsfb assertion failed in next cycle");

`endif

// ===== hdl/bsfb_pkg.sv =====
// Package for the bit-stuffing frame builder: sizes, flag pattern, plan type.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bsfb_pkg;

  localparam int TYPE_BITS = 16;
  localparam int PAD_BITS  = 21;
  localparam int STUFF_RUN = 5;
  localparam int ADDR_BITS = 3;
  localparam int FLAG_BITS = 8;
  localparam int RUN_W     = 3;

  localparam logic [FLAG_BITS-1:0] FLAG = 8'b0111_1110;

  localparam int HDR_BITS = FLAG_BITS + 2 * ADDR_BITS + TYPE_BITS;
  localparam int TRL_BITS = PAD_BITS + 1 + FLAG_BITS;
  localparam int SEQ_BITS = HDR_BITS + 2 + TRL_BITS;
  localparam int CNT_W    = $clog2(SEQ_BITS + 1);

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [RUN_W-1:0]    run_t;

  // Bit sequence for one item, first line bit in bit 0.
  typedef struct packed {
    seq_t seq;
    cnt_t len;
    logic trl;
  } plan_t;

  function automatic logic [ADDR_BITS-1:0] rev_addr(input logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS-1:0] r;
    for (int i = 0; i < ADDR_BITS; i++) begin
      r[i] = a[ADDR_BITS-1-i];
    end
    return r;
  endfunction

  function automatic logic [TYPE_BITS-1:0] rev_type(input logic [TYPE_BITS-1:0] t);
    logic [TYPE_BITS-1:0] r;
    for (int i = 0; i < TYPE_BITS; i++) begin
      r[i] = t[TYPE_BITS-1-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/bsfb_plan.sv =====
// Frame state and per-item plan: header, payload, stuffed zero, trailer.
// Depends on bsfb_pkg.
`timescale 1ns / 1ps

module bsfb_plan
  import bsfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 payload_bit_i,
  input  logic                 frame_start_i,
  input  logic                 frame_finish_i,
  input  logic [ADDR_BITS-1:0] receiver_addr_i,
  input  logic [ADDR_BITS-1:0] source_addr_i,
  input  logic [15:0]          frame_type_i,
  output plan_t                plan_o
);

  run_t ones_run_q, ones_run_d;
  logic parity_q, parity_d;
  logic in_frame_q, in_frame_d;

  logic                active;
  logic                par_base;
  logic                par_new;
  run_t                run_base;
  run_t                run_inc;
  logic                stuff;
  logic [TYPE_BITS-1:0] ftype;
  logic [HDR_BITS-1:0] hdr;
  logic [TRL_BITS-1:0] trl;
  seq_t                seq;

  assign ftype  = frame_type_i[TYPE_BITS-1:0];
  assign active = frame_start_i | in_frame_q;

  always_comb begin
    // Header restarts parity and the run of ones.
    par_base = frame_start_i ? ^{receiver_addr_i, source_addr_i, ftype} : parity_q;
    par_new  = par_base ^ payload_bit_i;
    run_base = frame_start_i ? '0 : ones_run_q;
    run_inc  = run_base + run_t'(1);
    stuff    = payload_bit_i && (run_inc >= run_t'(STUFF_RUN));

    hdr = {rev_type(ftype), rev_addr(source_addr_i), rev_addr(receiver_addr_i), FLAG};
    trl = '0;
    trl[PAD_BITS] = ~par_new;
    trl[TRL_BITS-1 -: FLAG_BITS] = FLAG;

    // Stuffed zero needs no bit: the sequence starts cleared.
    seq = '0;
    if (frame_start_i) begin
      seq[HDR_BITS-1:0] = hdr;
      seq[HDR_BITS]     = payload_bit_i;
    end else begin
      seq[0] = payload_bit_i;
    end
    if (frame_finish_i) begin
      case ({frame_start_i, stuff})
        2'b00:   seq = seq | (seq_t'(trl) << 1);
        2'b01:   seq = seq | (seq_t'(trl) << 2);
        2'b10:   seq = seq | (seq_t'(trl) << (HDR_BITS + 1));
        2'b11:   seq = seq | (seq_t'(trl) << (HDR_BITS + 2));
        default: seq = seq;
      endcase
    end

    plan_o.seq = seq;
    plan_o.trl = frame_finish_i;
    if (active) begin
      plan_o.len = cnt_t'(1) + cnt_t'(stuff)
                 + (frame_start_i  ? cnt_t'(HDR_BITS) : '0)
                 + (frame_finish_i ? cnt_t'(TRL_BITS) : '0);
    end else begin
      plan_o.len = '0;
    end

    ones_run_d = ones_run_q;
    parity_d   = parity_q;
    in_frame_d = in_frame_q;
    if (accept_i && active) begin
      in_frame_d = ~frame_finish_i;
      parity_d   = frame_finish_i ? 1'b0 : par_new;
      if (frame_finish_i || !payload_bit_i || stuff) begin
        ones_run_d = '0;
      end else begin
        ones_run_d = run_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_run_q <= '0;
      parity_q   <= 1'b0;
      in_frame_q <= 1'b0;
    end else begin
      ones_run_q <= ones_run_d;
      parity_q   <= parity_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// ===== hdl/bsfb_serializer.sv =====
// Sequence and output registers: one line bit out per cycle unless stalled.
// Depends on bsfb_pkg.
`timescale 1ns / 1ps

module bsfb_serializer
  import bsfb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  plan_t plan_i,
  output logic  ready_o,
  output logic  m_valid_o,
  input  logic  m_ready_i,
  output logic  line_bit_o,
  output logic  run_last_o,
  output logic  frame_end_o
);

  seq_t seq_q, seq_d;
  cnt_t cnt_q, cnt_d;
  logic trl_q, trl_d;
  logic valid_q, valid_d;
  logic bit_q, bit_d;
  logic last_q, last_d;
  logic end_q, end_d;

  logic out_free;
  logic emit;
  logic final_bit;

  assign out_free  = ~valid_q | m_ready_i;
  assign emit      = out_free && (cnt_q != '0);
  assign final_bit = (cnt_q == cnt_t'(1));
  // Take a new item as soon as the last bit of the current one moves out.
  assign ready_o   = (cnt_q == '0) || (final_bit && emit);

  always_comb begin
    seq_d   = seq_q;
    cnt_d   = cnt_q;
    trl_d   = trl_q;
    valid_d = valid_q;
    bit_d   = bit_q;
    last_d  = last_q;
    end_d   = end_q;

    if (emit) begin
      valid_d = 1'b1;
      bit_d   = seq_q[0];
      last_d  = final_bit;
      end_d   = final_bit & trl_q;
      seq_d   = seq_q >> 1;
      cnt_d   = cnt_q - cnt_t'(1);
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end

    if (load_i) begin
      seq_d = plan_i.seq;
      cnt_d = plan_i.len;
      trl_d = plan_i.trl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    trl_q  <= trl_d;
    bit_q  <= bit_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

  assign m_valid_o   = valid_q;
  assign line_bit_o  = bit_q;
  assign run_last_o  = last_q;
  assign frame_end_o = end_q;

endmodule

// ===== hdl/bit_stuffing_frame_builder.sv =====
// Top level of the bit-stuffing frame builder (HDLC-style serial framer).
// Depends on bsfb_pkg, bsfb_plan, bsfb_serializer and the defines header.
//
// Usage:
//   Slave stream: one payload bit per item. tuser marks the first bit of a
//   frame (header goes out first), tlast marks the last (trailer follows).
//   Addresses and type are sampled only with the first bit.
//   Master stream: one line bit per item. tlast closes the run of bits caused
//   by one input item, tuser flags the final bit of the closing flag.
//   The plan loads into the sequence register at the accepting edge; the first
//   line bit then moves into the output register, where the receiver takes it.
//   Line bits: an item causes one line bit mid-frame, 2 with a stuffed zero,
//   30 more for a header and 30 more for a trailer, 62 at most. The sequence
//   shift register emits one bit per cycle while the receiver takes bits, and a
//   new item loads in the cycle its predecessor's last bit leaves.
//   Items outside a frame produce no bits and leave tready high.
//   Reset: asynchronous, active low; clears the run of ones, parity, the
//   in-frame flag, the pending bit count and the output valid.
//   Receiver stall: the output register holds its bit, the sequence register
//   holds, and tready drops once the current item still has bits to send.
`timescale 1ns / 1ps
`include "bit_stuffing_frame_builder_defines.svh"

module bit_stuffing_frame_builder
  import bsfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] payload_bit, [3:1] receiver_addr, [6:4] source_addr,
  // [22:7] frame_type, [23] zero
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // frame_finish
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] line_bit, [7:1] zero
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // frame_end
);

  logic  accept;
  plan_t plan;
  logic  line_bit;

  // An item enters when valid meets ready; the plan is built on the same edge.
  assign accept = s_axis_tvalid & s_axis_tready;

  bsfb_plan u_plan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .payload_bit_i   (s_axis_tdata[0]),
    .frame_start_i   (s_axis_tuser),
    .frame_finish_i  (s_axis_tlast),
    .receiver_addr_i (s_axis_tdata[3:1]),
    .source_addr_i   (s_axis_tdata[6:4]),
    .frame_type_i    (s_axis_tdata[22:7]),
    .plan_o          (plan)
  );

  // Hold the bit sequence of one item and advance it as the receiver takes bits.
  bsfb_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .plan_i      (plan),
    .ready_o     (s_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .line_bit_o  (line_bit),
    .run_last_o  (m_axis_tlast),
    .frame_end_o (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, line_bit};

  // The closing flag bit ends the run of its item and is a zero.
  `BSFB_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `BSFB_ASSERT_NOW(a_end_is_zero, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[0])
  // A header keeps the serializer busy, so no item follows a frame start directly.
  `BSFB_ASSERT_NEXT(a_hdr_busy, accept && s_axis_tuser, !s_axis_tready)

endmodule

// ===== dv/bsfb_line_checker.sv =====
// Scoreboard for the bit-stuffing frame builder: watches both streams, predicts line bits.
// Depends on bsfb_pkg for field widths, the flag pattern and the trailer sizes.
`timescale 1ns / 1ps

module bsfb_line_checker
  import bsfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          due_count
);

  typedef struct packed {
    logic line_bit;
    logic run_last;
    logic frame_end;
  } line_out_t;

  line_out_t line_due_q[$];
  run_t      ones_run;
  logic      parity_acc;
  logic      in_frame;
  int        mismatches = 0;

  // Add one expected line bit at the tail of the pending list.
  task automatic append_due(input line_out_t entry);
    line_due_q = {line_due_q, entry};
  endtask

  // Append the line bits one payload item causes, header and trailer included.
  task automatic predict_line_bits(input logic pbit, input logic start, input logic finish,
                                   input logic [ADDR_BITS-1:0] rx_addr,
                                   input logic [ADDR_BITS-1:0] tx_addr,
                                   input logic [TYPE_BITS-1:0] ftype);
    logic [SEQ_BITS-1:0] bits;
    int n;
    line_out_t entry;
    bits = '0;
    n = 0;
    if (start) begin
      // a start always opens a fresh frame, dropping any open one
      ones_run = '0;
      parity_acc = 1'b0;
      in_frame = 1'b1;
      for (int i = FLAG_BITS - 1; i >= 0; i--) begin
        bits[n] = FLAG[i];
        n++;
      end
      for (int i = ADDR_BITS - 1; i >= 0; i--) begin
        bits[n] = rx_addr[i];
        parity_acc ^= rx_addr[i];
        n++;
      end
      for (int i = ADDR_BITS - 1; i >= 0; i--) begin
        bits[n] = tx_addr[i];
        parity_acc ^= tx_addr[i];
        n++;
      end
      for (int i = TYPE_BITS - 1; i >= 0; i--) begin
        bits[n] = ftype[i];
        parity_acc ^= ftype[i];
        n++;
      end
    end
    // idle items outside a frame leave no trace
    if (!in_frame) return;

    bits[n] = pbit;
    parity_acc ^= pbit;
    n++;
    if (pbit) begin
      ones_run = ones_run + 1'b1;
      if (ones_run >= STUFF_RUN) begin
        n++;  // stuffed zero, already clear in bits
        ones_run = '0;
      end
    end else begin
      ones_run = '0;
    end

    if (finish) begin
      n += PAD_BITS;
      bits[n] = ~parity_acc;
      n++;
      for (int i = FLAG_BITS - 1; i >= 0; i--) begin
        bits[n] = FLAG[i];
        n++;
      end
      in_frame = 1'b0;
      ones_run = '0;
      parity_acc = 1'b0;
    end

    for (int i = 0; i < n; i++) begin
      entry.line_bit  = bits[i];
      entry.run_last  = (i == n - 1);
      entry.frame_end = finish && (i == n - 1);
      append_due(entry);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_out_t want;
    if (!rst_ni) begin
      ones_run   = '0;
      parity_acc = 1'b0;
      in_frame   = 1'b0;
      line_due_q.delete();
      due_count  <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_line_bits(s_axis_tdata[0], s_axis_tuser, s_axis_tlast, s_axis_tdata[3:1],
                          s_axis_tdata[6:4], s_axis_tdata[22:7]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_due_q.size() == 0) begin
          $error("unexpected line bit %0b with nothing pending", m_axis_tdata[0]);
          mismatches++;
        end else begin
          want = line_due_q.pop_front();
          if (m_axis_tdata[0] !== want.line_bit) begin
            $error("line_bit: expected %0b, got %0b", want.line_bit, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tlast !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[7:1] !== 7'd0) begin
            $error("tdata fill: expected 0, got %0h", m_axis_tdata[7:1]);
            mismatches++;
          end
        end
      end
      fail_count <= mismatches;
      due_count  <= line_due_q.size();
    end
  end

endmodule

// ===== dv/bit_stuffing_frame_builder_tb.sv =====
// Testbench top for the bit-stuffing frame builder: clock, reset, payload stimulus, verdict.
// Depends on bsfb_pkg, the block itself and bsfb_line_checker.
`timescale 1ns / 1ps

module bit_stuffing_frame_builder_tb;
  import bsfb_pkg::*;

  typedef struct {
    logic                 payload_bit;
    logic                 frame_start;
    logic                 frame_finish;
    logic [ADDR_BITS-1:0] receiver_addr;
    logic [ADDR_BITS-1:0] source_addr;
    logic [TYPE_BITS-1:0] frame_type;
  } payload_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int fail_count;
  int due_count;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  bit_stuffing_frame_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  bsfb_line_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .due_count     (due_count)
  );

  function automatic payload_item_t mk_item(input logic pbit, input logic start,
                                            input logic finish,
                                            input logic [ADDR_BITS-1:0] rx_addr,
                                            input logic [ADDR_BITS-1:0] tx_addr,
                                            input logic [TYPE_BITS-1:0] ftype);
    payload_item_t it;
    it.payload_bit   = pbit;
    it.frame_start   = start;
    it.frame_finish  = finish;
    it.receiver_addr = rx_addr;
    it.source_addr   = tx_addr;
    it.frame_type    = ftype;
    return it;
  endfunction

  // Offer one item, with random idle cycles ahead of it; return once it is taken.
  task automatic offer_item(input payload_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.frame_type, it.source_addr, it.receiver_addr, it.payload_bit};
    s_axis_tlast  <= it.frame_finish;
    s_axis_tuser  <= it.frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Addresses stay mostly in the supported range, now and then 6 or 7.
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    return ($urandom_range(9) == 0) ? ADDR_BITS'($urandom_range(7))
                                    : ADDR_BITS'($urandom_range(5));
  endfunction

  // Send well-formed frames with random content, some idle noise and some
  // frames cut short by the next start, until the payload count is reached.
  task automatic send_random_frames(input int payload_goal);
    int sent;
    int len;
    int ones_pct;
    bit cut_short;
    bit open_frame;
    sent = 0;
    open_frame = 1'b0;
    while (sent < payload_goal) begin
      if (!open_frame && $urandom_range(99) < 6) begin
        offer_item(mk_item(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), pick_addr(),
                           pick_addr(), TYPE_BITS'($urandom)));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 10);
        ones_pct = ($urandom_range(1) == 1) ? 90 : 50;
        cut_short = ($urandom_range(99) < 8);
        for (int i = 0; i < len; i++) begin
          offer_item(mk_item($urandom_range(99) < ones_pct, i == 0,
                             (i == len - 1) && !cut_short, pick_addr(), pick_addr(),
                             TYPE_BITS'($urandom)));
        end
        open_frame = cut_short;
        sent += len;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : rx_ready_gen
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    #(600_000 * 12);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle items outside a frame, finish alone included
    offer_item(mk_item(1'b1, 1'b0, 1'b0, 3'd5, 3'd2, 16'h1234));
    offer_item(mk_item(1'b0, 1'b0, 1'b1, 3'd7, 3'd7, 16'hFFFF));
    // one-bit frames at both extremes, addresses 0 and 7 among them
    offer_item(mk_item(1'b0, 1'b1, 1'b1, 3'd0, 3'd0, 16'h0000));
    offer_item(mk_item(1'b1, 1'b1, 1'b1, 3'd7, 3'd7, 16'hFFFF));
    // runs of ones that force two stuffed zeros in one frame
    offer_item(mk_item(1'b1, 1'b1, 1'b0, 3'd6, 3'd5, 16'hA5C3));
    for (int i = 0; i < 9; i++) begin
      offer_item(mk_item(1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 16'h0000));
    end
    offer_item(mk_item(1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 16'h0000));
    offer_item(mk_item(1'b1, 1'b0, 1'b1, 3'd0, 3'd0, 16'h0000));
    // restart inside an open frame drops it without a trailer
    offer_item(mk_item(1'b1, 1'b1, 1'b0, 3'd5, 3'd0, 16'h00FF));
    offer_item(mk_item(1'b1, 1'b0, 1'b0, 3'd1, 3'd1, 16'h0F0F));
    offer_item(mk_item(1'b0, 1'b1, 1'b0, 3'd2, 3'd6, 16'h8001));
    offer_item(mk_item(1'b1, 1'b0, 1'b0, 3'd3, 3'd4, 16'h7FFE));
    offer_item(mk_item(1'b0, 1'b0, 1'b1, 3'd4, 3'd3, 16'h5555));

    // no idling; hold the receiver off long enough to back up the input
    long_hold_req <= 1'b1;
    send_random_frames(64);
    tx_idle_pct = 80;
    rx_stall_pct = 0;
    send_random_frames(64);
    tx_idle_pct = 0;
    rx_stall_pct = 80;
    send_random_frames(64);
    tx_idle_pct = 17;
    rx_stall_pct = 17;
    send_random_frames(64);

    s_axis_tvalid <= 1'b0;
    rx_stall_pct = 0;
    while (due_count != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (due_count != 0) begin
      $error("%0d expected line bits never arrived", due_count);
    end
    if (fail_count == 0 && due_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== bit_stuffing_frame_builder.f =====
+incdir+hdl
hdl/bsfb_pkg.sv
hdl/bsfb_plan.sv
hdl/bsfb_serializer.sv
hdl/bit_stuffing_frame_builder.sv
dv/bsfb_line_checker.sv
dv/bit_stuffing_frame_builder_tb.sv
